[rtl/c2p_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared widths, types, constants and arctangent table for the converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

  // Number of rotation cells in the chain (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  localparam int CW      = 16;        // coordinate width
  localparam int FRAC    = 24;        // fractional bits of x/y in the chain
  localparam int DW      = 44;        // x/y width in the chain
  localparam int ZW      = 34;        // angle accumulator width, 2^31 = pi
  localparam int STAGE_W = 5;         // cell index width
  localparam int MW      = DW - 1 + 16; // gain product width
  localparam int RW      = 25;        // radius width
  localparam int AW      = 17;        // angle width

  localparam logic [15:0]   INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0]   INV_GAIN_LO = 16'hEDA8;
  localparam logic [RW-1:0] RADIUS_MAX  = 25'd23726592;

  // register indexes
  localparam logic [2:0] REG_IMAGE_MODE = 3'd0;
  localparam logic [2:0] REG_CENTER_ROW = 3'd1;
  localparam logic [2:0] REG_CENTER_COL = 3'd2;
  localparam logic [2:0] REG_NUM_ROWS   = 3'd3;
  localparam logic [2:0] REG_NUM_COLS   = 3'd4;

  typedef struct packed {
    logic                 image_mode;
    logic signed [CW-1:0] center_row;
    logic signed [CW-1:0] center_col;
    logic        [CW-1:0] num_rows;
    logic        [CW-1:0] num_cols;
  } cfg_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 y_nonneg;
    logic                 nonzero;
    logic                 oor;
    logic                 batch_end;
  } cordic_t;

  // atan(2^-i) scaled so that 2^31 = pi, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_val(input logic [STAGE_W-1:0] i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        5'd0:    v = 34'sd536870912;
        5'd1:    v = 34'sd316933406;
        5'd2:    v = 34'sd167458907;
        5'd3:    v = 34'sd85004756;
        5'd4:    v = 34'sd42667331;
        5'd5:    v = 34'sd21354465;
        5'd6:    v = 34'sd10679838;
        5'd7:    v = 34'sd5340245;
        5'd8:    v = 34'sd2670163;
        5'd9:    v = 34'sd1335087;
        5'd10:   v = 34'sd667544;
        5'd11:   v = 34'sd333772;
        5'd12:   v = 34'sd166886;
        5'd13:   v = 34'sd83443;
        5'd14:   v = 34'sd41722;
        5'd15:   v = 34'sd20861;
        5'd16:   v = 34'sd10430;
        5'd17:   v = 34'sd5215;
        5'd18:   v = 34'sd2608;
        5'd19:   v = 34'sd1304;
        5'd20:   v = 34'sd652;
        5'd21:   v = 34'sd326;
        5'd22:   v = 34'sd163;
        5'd23:   v = 34'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/cartesian_to_polar_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar_converter
// Streaming coordinate pair to radius/angle converter, CORDIC vectoring.
// ----------------------------------------------------------------------------
// Takes one coordinate pair per clock unless the chain is backed up, and
// returns radius = sqrt(x^2+y^2) in units of 1/256 and angle = atan2(y,x) as
// a 17-bit binary angle (+32768 = pi, origin gives 0). An item passes the
// input stage, one cell per micro-rotation, the gain product stage and the
// rounding/result register. Every stage has its own valid bit and ready is
// passed back stage by stage, so bubbles are squeezed out and input is taken
// even while a result sits unclaimed at the output. In image mode the inputs
// are a pixel row and column: x = col - center_col, y = center_row - row, and
// out_of_range flags a row or column outside num_rows/num_cols (the conversion
// is still done). Registers are written through the cfg channel, always ready;
// an index past the last register is ignored. Write them only while the block
// is empty.
// ----------------------------------------------------------------------------
module cartesian_to_polar_converter (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [c2p_pkg::CW-1:0] first_coord,
  input  logic signed [c2p_pkg::CW-1:0] second_coord,
  input  logic                          end_of_batch,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c2p_pkg::RW-1:0]        radius,
  output logic signed [c2p_pkg::AW-1:0] angle,
  output logic                          out_of_range,
  output logic                          batch_end
);
  import c2p_pkg::*;

  cfg_t cfg;

  // chain links: index 0 is the front stage output, index k the k-th cell
  cordic_t chain_data  [0:CORDIC_STAGES];
  logic    chain_valid [0:CORDIC_STAGES];
  logic    chain_ready [0:CORDIC_STAGES];

  // --- configuration registers ---
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_mode <= 1'b0;
      cfg.center_row <= '0;
      cfg.center_col <= '0;
      cfg.num_rows   <= 16'd512;
      cfg.num_cols   <= 16'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_MODE: cfg.image_mode <= cfg_data[0];
        REG_CENTER_ROW: cfg.center_row <= $signed(cfg_data);
        REG_CENTER_COL: cfg.center_col <= $signed(cfg_data);
        REG_NUM_ROWS:   cfg.num_rows   <= cfg_data;
        REG_NUM_COLS:   cfg.num_cols   <= cfg_data;
        default: ;      // unmapped index: write dropped
      endcase
    end
  end

  // --- mapping, range flag and quadrant fold ---
  c2p_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .end_of_batch (end_of_batch),
    .dn_valid     (chain_valid[0]),
    .dn_ready     (chain_ready[0]),
    .dn_data      (chain_data[0])
  );

  // --- micro-rotation cells, one shift/add step each ---
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    c2p_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (STAGE_W'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  // --- 1/K scaling, rounding, clamps; result register ---
  c2p_gain u_gain (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (chain_valid[CORDIC_STAGES]),
    .up_ready     (chain_ready[CORDIC_STAGES]),
    .up_data      (chain_data[CORDIC_STAGES]),
    .dn_valid     (out_valid),
    .dn_ready     (out_ready),
    .radius       (radius),
    .angle        (angle),
    .out_of_range (out_of_range),
    .batch_end    (batch_end)
  );

endmodule
`default_nettype wire

[rtl/c2p_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_front
// Input stage: coordinate mapping, range flag, quadrant pre-rotation.
// ----------------------------------------------------------------------------
module c2p_front (
  input  logic                        clk,
  input  logic                        rst,
  input  c2p_pkg::cfg_t               cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [c2p_pkg::CW-1:0] first_coord,
  input  logic signed [c2p_pkg::CW-1:0] second_coord,
  input  logic                        end_of_batch,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output c2p_pkg::cordic_t            dn_data
);
  import c2p_pkg::*;

  logic signed [CW:0]   xa, ya;
  logic signed [CW+1:0] xe, ye, xr, yr;
  logic signed [ZW-1:0] z0;
  logic                 oor;
  cordic_t              nxt;

  always_comb begin
    if (cfg.image_mode) begin
      xa = $signed({second_coord[CW-1], second_coord})
         - $signed({cfg.center_col[CW-1], cfg.center_col});
      ya = $signed({cfg.center_row[CW-1], cfg.center_row})
         - $signed({first_coord[CW-1], first_coord});
    end else begin
      xa = $signed({first_coord[CW-1], first_coord});
      ya = $signed({second_coord[CW-1], second_coord});
    end
    xe = $signed({xa[CW], xa});
    ye = $signed({ya[CW], ya});

    // left half-plane: turn by a quarter so the chain starts with x >= 0
    if (xa[CW]) begin
      if (!ya[CW]) begin
        xr = ye;
        yr = -xe;
        z0 = $signed(ZW'(64'sd1 << 30));
      end else begin
        xr = -ye;
        yr = xe;
        z0 = -$signed(ZW'(64'sd1 << 30));
      end
    end else begin
      xr = xe;
      yr = ye;
      z0 = '0;
    end

    oor = cfg.image_mode &
          (first_coord[CW-1] | ($unsigned(first_coord) >= cfg.num_rows) |
           second_coord[CW-1] | ($unsigned(second_coord) >= cfg.num_cols));

    nxt.x         = $signed({{(DW-CW-2-FRAC){xr[CW+1]}}, xr, {FRAC{1'b0}}});
    nxt.y         = $signed({{(DW-CW-2-FRAC){yr[CW+1]}}, yr, {FRAC{1'b0}}});
    nxt.z         = z0;
    nxt.y_nonneg  = ~ya[CW];
    nxt.nonzero   = (xa != '0) | (ya != '0);
    nxt.oor       = oor;
    nxt.batch_end = end_of_batch;
  end

  assign up_ready = ~dn_valid | dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/c2p_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_cell
// One vectoring micro-rotation with its own item register.
// ----------------------------------------------------------------------------
module c2p_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [c2p_pkg::STAGE_W-1:0]    stage,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  c2p_pkg::cordic_t               up_data,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output c2p_pkg::cordic_t               dn_data
);
  import c2p_pkg::*;

  logic signed [DW-1:0] dx, dy;
  cordic_t              nxt;

  always_comb begin
    dx  = up_data.y >>> stage;   // floor shift
    dy  = up_data.x >>> stage;
    nxt = up_data;
    if (!up_data.y[DW-1]) begin
      nxt.x = up_data.x + dx;
      nxt.y = up_data.y - dy;
      nxt.z = up_data.z + atan_val(stage);
    end else begin
      nxt.x = up_data.x - dx;
      nxt.y = up_data.y + dy;
      nxt.z = up_data.z - atan_val(stage);
    end
  end

  assign up_ready = ~dn_valid | dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/c2p_gain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_gain
// Gain correction and rounding of radius and angle; holds the result register.
// ----------------------------------------------------------------------------
module c2p_gain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  c2p_pkg::cordic_t            up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [c2p_pkg::RW-1:0]      radius,
  output logic signed [c2p_pkg::AW-1:0] angle,
  output logic                        out_of_range,
  output logic                        batch_end
);
  import c2p_pkg::*;

  // product stage
  logic                 m_valid, m_ready;
  logic [MW-1:0]        m_hi, m_lo;
  logic                 m_pos;
  logic signed [ZW-1:0] m_z;
  logic                 m_y_nonneg, m_nonzero, m_oor, m_batch_end;

  logic [DW-2:0]        ux;
  logic                 pos;

  // final stage
  logic [MW:0]            psum;
  logic [MW-32:0]         r;
  logic [RW-1:0]          rad_next;
  logic signed [ZW:0]     zs;
  logic signed [ZW-16:0]  zr;
  logic signed [AW-1:0]   ang_next;

  always_comb begin
    pos = ~up_data.x[DW-1] & (up_data.x != '0);
    ux  = up_data.x[DW-2:0];
  end

  assign up_ready = ~m_valid | m_ready;
  assign m_ready  = ~dn_valid | dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (up_ready) begin
      m_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      m_hi        <= MW'(ux) * MW'(INV_GAIN_HI);
      m_lo        <= MW'(ux) * MW'(INV_GAIN_LO);
      m_pos       <= pos;
      m_z         <= up_data.z;
      m_y_nonneg  <= up_data.y_nonneg;
      m_nonzero   <= up_data.nonzero;
      m_oor       <= up_data.oor;
      m_batch_end <= up_data.batch_end;
    end
  end

  always_comb begin
    // low product truncated by 16, then round half up to 1/256
    psum = (MW+1)'(m_hi) + (MW+1)'(m_lo[MW-1:16]) + (MW+1)'(64'd1 << 31);
    r    = psum[MW:32];
    if (!m_pos) begin
      rad_next = '0;
    end else if (r > (MW-31)'(RADIUS_MAX)) begin
      rad_next = RADIUS_MAX;
    end else begin
      rad_next = r[RW-1:0];
    end

    zs = $signed({m_z[ZW-1], m_z}) + $signed((ZW+1)'(32768));
    zr = zs[ZW:16];
    if (!m_nonzero) begin
      ang_next = '0;
    end else if (m_y_nonneg) begin
      if (zr < 0) begin
        ang_next = '0;
      end else if (zr > $signed((ZW-15)'(32768))) begin
        ang_next = $signed(AW'(32768));
      end else begin
        ang_next = zr[AW-1:0];
      end
    end else begin
      if (zr > 0) begin
        ang_next = '0;
      end else if (zr < -$signed((ZW-15)'(32767))) begin
        ang_next = -$signed(AW'(32767));
      end else begin
        ang_next = zr[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (m_ready) begin
      dn_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && m_valid) begin
      radius       <= rad_next;
      angle        <= ang_next;
      out_of_range <= m_oor;
      batch_end    <= m_batch_end;
    end
  end

endmodule
`default_nettype wire

[rtl/c2p_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module c2p_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [c2p_pkg::RW-1:0]        radius,
  input  logic signed [c2p_pkg::AW-1:0] angle,
  input  logic                          out_of_range,
  input  logic                          batch_end
);
  import c2p_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(angle)
      && $stable(out_of_range) && $stable(batch_end))
    else $error("result changed while stalled");

  // empty result register means the chain can always take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  a_radius_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> radius <= RADIUS_MAX)
    else $error("radius above saturation limit");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= $signed(AW'(32768))) && (angle >= -$signed(AW'(32767))))
    else $error("angle outside half-open range");

  // zero radius only comes from the origin, whose angle is zero
  a_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (radius == '0) |-> angle == '0)
    else $error("zero radius with non-zero angle");

endmodule

bind cartesian_to_polar_converter c2p_checker u_c2p_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .radius       (radius),
  .angle        (angle),
  .out_of_range (out_of_range),
  .batch_end    (batch_end)
);
`default_nettype wire

[dv/cartesian_to_polar_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_converter_tb
// Self-checking bench: streams coordinate pairs through the converter under
// random source and sink pacing, predicts radius, angle and flags in fixed
// point, and compares every result item in order across several register
// settings.
// ----------------------------------------------------------------------------

// Holds a shadow of the registers and the queue of predicted results.
class polar_check;

  typedef struct packed {
    logic [c2p_pkg::RW-1:0]        radius;
    logic signed [c2p_pkg::AW-1:0] angle;
    logic                          out_of_range;
    logic                          batch_end;
  } polar_t;

  bit     image_mode;
  longint origin_row;
  longint origin_col;
  longint rows;
  longint cols;
  longint arctan_step[24];
  polar_t polar_due[$];
  int     mismatches;

  function new();
    arctan_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5340245, 2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861, 10430, 5215,
                    2608, 1304, 652, 326, 163, 81};
    image_mode = 1'b0;
    origin_row = 0;
    origin_col = 0;
    rows       = 512;
    cols       = 512;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] index, logic [15:0] data);
    case (index)
      c2p_pkg::REG_IMAGE_MODE: image_mode = data[0];
      c2p_pkg::REG_CENTER_ROW: origin_row = longint'($signed(data));
      c2p_pkg::REG_CENTER_COL: origin_col = longint'($signed(data));
      c2p_pkg::REG_NUM_ROWS:   rows = longint'(data);
      c2p_pkg::REG_NUM_COLS:   cols = longint'(data);
      default: ;
    endcase
  endfunction

  // CORDIC vectoring in 64-bit integers, x/y scaled by 2^24, 2^31 = pi
  function polar_t to_polar(logic signed [15:0] a, logic signed [15:0] b, logic eob);
    longint          x, y, cx, cy, z, t, dx, dy, ang;
    longint unsigned ux, p, r;
    bit              y_nonneg;
    polar_t          res;
    res = '0;
    res.batch_end = eob;
    if (image_mode) begin
      x = longint'(b) - origin_col;
      y = origin_row - longint'(a);
      res.out_of_range = (a < 0) || (longint'(a) >= rows) ||
                         (b < 0) || (longint'(b) >= cols);
    end else begin
      x = longint'(a);
      y = longint'(b);
    end
    y_nonneg = (y >= 0);
    if (x != 0 || y != 0) begin
      cx = x <<< 24;
      cy = y <<< 24;
      z  = 0;
      // left half-plane: pre-rotate by a quarter turn
      if (cx < 0) begin
        t = cx;
        if (cy >= 0) begin
          cx = cy;
          cy = -t;
          z  = 1073741824;
        end else begin
          cx = -cy;
          cy = t;
          z  = -1073741824;
        end
      end
      for (int i = 0; i < c2p_pkg::CORDIC_STAGES && i < 24; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z  += arctan_step[i];
        end else begin
          cx -= dx;
          cy += dy;
          z  -= arctan_step[i];
        end
      end
      if (cx > 0) begin
        ux = longint'(cx);
        p  = ux * c2p_pkg::INV_GAIN_HI + ((ux * c2p_pkg::INV_GAIN_LO) >> 16);
        r  = (p + (64'd1 << 31)) >> 32;
        res.radius = (r > c2p_pkg::RADIUS_MAX) ? c2p_pkg::RADIUS_MAX : r[24:0];
      end
      ang = (z + 32768) >>> 16;
      if (y_nonneg) begin
        if (ang < 0) ang = 0;
        if (ang > 32768) ang = 32768;
      end else begin
        if (ang > 0) ang = 0;
        if (ang < -32767) ang = -32767;
      end
      res.angle = ang[16:0];
    end
    return res;
  endfunction

  function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic eob);
    polar_due.push_back(to_polar(a, b, eob));
  endfunction

  function int pending();
    return polar_due.size();
  endfunction

  function void check_result(logic [c2p_pkg::RW-1:0] rad, logic signed [c2p_pkg::AW-1:0] ang,
                             logic oor, logic be);
    polar_t want;
    if (polar_due.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none, actual radius %0d angle %0d",
               $time, rad, ang);
      mismatches++;
      return;
    end
    want = polar_due.pop_front();
    if (rad !== want.radius) begin
      $display("%0t: radius mismatch, expected %0d, actual %0d", $time, want.radius, rad);
      mismatches++;
    end
    if (ang !== want.angle) begin
      $display("%0t: angle mismatch, expected %0d, actual %0d", $time, want.angle, ang);
      mismatches++;
    end
    if (oor !== want.out_of_range) begin
      $display("%0t: out_of_range mismatch, expected %0b, actual %0b",
               $time, want.out_of_range, oor);
      mismatches++;
    end
    if (be !== want.batch_end) begin
      $display("%0t: batch_end mismatch, expected %0b, actual %0b", $time, want.batch_end, be);
      mismatches++;
    end
  endfunction

endclass

module cartesian_to_polar_converter_tb;
  import c2p_pkg::*;

  // pipeline depth plus a margin for the final quiet period
  localparam int DRAIN_CYCLES = CORDIC_STAGES + 3 + 8;
  // long sink hold-off, well past the pipeline depth so the input backs up
  localparam int HOLD_CYCLES  = 400;

  // coordinate extremes and values around zero
  localparam logic signed [15:0] EDGE_COORDS [6] = '{16'sh8000, 16'sh7FFF, -16'sd1,
                                                     16'sd0, 16'sd1, 16'sh4000};

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [2:0]           cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] first_coord;
  logic signed [CW-1:0] second_coord;
  logic                 end_of_batch;
  logic                 out_valid;
  logic                 out_ready;
  logic [RW-1:0]        radius;
  logic signed [AW-1:0] angle;
  logic                 out_of_range;
  logic                 batch_end;

  polar_check polar_ref;
  int         pairs_taken = 0;   // input items accepted so far
  int         burst_left  = 0;   // items left in the current source burst
  int         holds_done  = 0;

  cartesian_to_polar_converter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .end_of_batch (end_of_batch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .radius       (radius),
    .angle        (angle),
    .out_of_range (out_of_range),
    .batch_end    (batch_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one item and holds it until the handshake; the prediction is
  // taken with the register shadow as it stands at acceptance.
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic eob);
    in_valid     <= 1'b1;
    first_coord  <= a;
    second_coord <= b;
    end_of_batch <= eob;
    do @(posedge clk); while (!in_ready);
    polar_ref.note_pair(a, b, eob);
    pairs_taken++;
  endtask

  // Source pacing: bursts of random length, a random gap after each. The odd
  // long burst gives stretches with no idling at all.
  task automatic send_paced(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic eob);
    int gap;
    send_pair(a, b, eob);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Valid is dropped after every write, so back-to-back writes never raise
  // and lower it in the same step.
  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    polar_ref.write_reg(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [15:0] crow, input logic [15:0] ccol,
                            input logic [15:0] nrows, input logic [15:0] ncols);
    write_reg(REG_IMAGE_MODE, {15'd0, mode});
    write_reg(REG_CENTER_ROW, crow);
    write_reg(REG_CENTER_COL, ccol);
    write_reg(REG_NUM_ROWS, nrows);
    write_reg(REG_NUM_COLS, ncols);
  endtask

  // Every item gives exactly one result, so an empty queue means an empty
  // pipeline and the registers may be touched.
  task automatic drain_items();
    in_valid <= 1'b0;
    do @(posedge clk); while (polar_ref.pending() != 0);
  endtask

  // Mix of full-range pairs, pairs near the origin, points on the axes and
  // diagonals, pixels around the image border and plain extremes.
  task automatic random_pairs(input int count);
    logic signed [15:0] a, b;
    int                 sel;
    repeat (count) begin
      sel = $urandom_range(0, 11);
      case (sel)
        0, 1, 2, 3: begin
          a = 16'($urandom);
          b = 16'($urandom);
        end
        4, 5: begin
          a = 16'(int'($urandom_range(0, 8)) - 4);
          b = 16'(int'($urandom_range(0, 8)) - 4);
        end
        6: begin
          a = 16'($urandom);
          b = 16'sd0;
          if ($urandom_range(0, 1)) begin
            b = a;
            a = 16'sd0;
          end
        end
        7, 8: begin
          a = 16'(int'($urandom_range(0, 32'(polar_ref.rows) + 2)) - 1);
          b = 16'(int'($urandom_range(0, 32'(polar_ref.cols) + 2)) - 1);
        end
        9: begin
          a = 16'($urandom);
          b = $urandom_range(0, 1) ? a : -a;
        end
        default: begin
          a = EDGE_COORDS[$urandom_range(0, 5)];
          b = EDGE_COORDS[$urandom_range(0, 5)];
        end
      endcase
      send_paced(a, b, $urandom_range(0, 7) == 0);
    end
  endtask

  // Result monitor: every accepted result item is checked in order.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      polar_ref.check_result(radius, angle, out_of_range, batch_end);
    end
  end

  // Sink pacing: segments of always-ready, coin-toss, one-in-three and
  // mostly-ready. Twice the sink holds off for a long stretch while the
  // source keeps offering, so the pipeline fills and in_ready drops.
  initial begin
    int mode, len, beat;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ((holds_done == 0 && pairs_taken >= 150) || (holds_done == 1 && pairs_taken >= 900)) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 60);
      for (beat = 0; beat < len; beat++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (beat % 3 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Main sequence
  initial begin
    polar_ref    = new();
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    first_coord  <= '0;
    second_coord <= '0;
    end_of_batch <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plain mode from reset: origin, the four axis directions, pi from both
    // sides of the negative x axis, quadrant corners and full-scale extremes.
    send_paced(16'sd0, 16'sd0, 1'b0);
    send_paced(16'sd1, 16'sd0, 1'b0);
    send_paced(16'sd0, 16'sd1, 1'b0);
    send_paced(-16'sd1, 16'sd0, 1'b0);
    send_paced(16'sh8000, 16'sd0, 1'b1);
    send_paced(16'sd0, -16'sd1, 1'b0);
    send_paced(16'sh8000, -16'sd1, 1'b0);
    send_paced(16'sh8000, 16'sh8000, 1'b0);
    send_paced(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_paced(16'sh7FFF, 16'sh8000, 1'b0);
    send_paced(16'sh8000, 16'sh7FFF, 1'b0);
    send_paced(16'sd1, -16'sd1, 1'b0);
    send_paced(-16'sd1, 16'sd1, 1'b0);
    send_paced(-16'sd1, -16'sd1, 1'b1);
    random_pairs(350);
    drain_items();

    // Image mode, centred 512x512 picture: the centre pixel maps to the
    // origin; each border is crossed on both sides.
    set_config(1'b1, 16'd256, 16'd256, 16'd512, 16'd512);
    send_paced(16'sd256, 16'sd256, 1'b0);
    send_paced(16'sd0, 16'sd0, 1'b0);
    send_paced(16'sd511, 16'sd511, 1'b0);
    send_paced(-16'sd1, 16'sd0, 1'b0);
    send_paced(16'sd0, 16'sd512, 1'b0);
    send_paced(16'sd512, 16'sd0, 1'b0);
    send_paced(16'sd0, -16'sd1, 1'b0);
    send_paced(16'sh7FFF, 16'sh8000, 1'b1);
    random_pairs(350);
    drain_items();

    // Origin at the far corner, tallest image, one column wide.
    set_config(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'd1);
    send_paced(16'sh7FFF, 16'sh8000, 1'b1);
    random_pairs(250);
    drain_items();

    // Opposite corner; zero rows flags every pixel, widest register value.
    // The far pixel gives the largest radius the inputs can reach.
    set_config(1'b1, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
    send_paced(16'sh8000, 16'sh7FFF, 1'b0);
    send_paced(16'sh7FFF, 16'sh8000, 1'b1);
    random_pairs(250);
    drain_items();

    // Writes past the last register must leave the settings alone; back in
    // plain mode the centre and size registers must have no effect.
    for (int k = REG_NUM_COLS + 1; k < 8; k++) begin
      write_reg(3'(k), 16'($urandom));
    end
    set_config(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_pairs(200);
    drain_items();

    // A few small random pictures with the origin somewhere near them.
    repeat (3) begin
      set_config(1'b1, 16'($urandom_range(0, 1023) - 256), 16'($urandom_range(0, 1023) - 256),
                 16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)));
      random_pairs(80);
      drain_items();
    end

    // Quiet period to catch any result item with nothing behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (polar_ref.mismatches == 0) begin
      $display("cartesian_to_polar_converter regression: pass");
    end else begin
      $display("cartesian_to_polar_converter regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("cartesian_to_polar_converter regression: fail");
    $finish;
  end

endmodule
